[rtl/double_ended_queue_defines.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Opcodes, status codes and shared types of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned AMT_W   = 8;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned OCC_W   = 7;

	localparam logic [OP_W-1:0] OP_PUSH_REAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_POS    = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_K    = 3'd5;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	// result queue between front and back
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW    = 2;
	localparam int unsigned RQ_CW    = 3;

	typedef struct packed {
		logic signed [WORD_W-1:0] value_out;
		logic [ST_W-1:0]          status;
		logic [AMT_W-1:0]         removed;
		logic [OCC_W-1:0]         occupancy;
	} dq_rsp_t;

	// beat in flight from front to back, aligned with RAM read data
	typedef struct packed {
		logic    valid;
		logic    rd;
		dq_rsp_t rsp;
	} dq_pend_t;

endpackage

[rtl/dq_req_if.sv]
// ----------------------------------------------------------------------------
// dq_req_if
// Request channel: operation, push word and position/count.
// ----------------------------------------------------------------------------
interface dq_req_if;
	logic                                valid;
	logic                                ready;
	logic [dq_pkg::OP_W-1:0]             operation;
	logic signed [dq_pkg::WORD_W-1:0]    value_in;
	logic [dq_pkg::AMT_W-1:0]            amount;

	modport source (output valid, operation, value_in, amount, input ready);
	modport sink   (input valid, operation, value_in, amount, output ready);
endinterface

[rtl/dq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dq_rsp_if
// Result channel: value, status, removal count and occupancy.
// ----------------------------------------------------------------------------
interface dq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [dq_pkg::WORD_W-1:0]    value_out;
	logic [dq_pkg::ST_W-1:0]             status;
	logic [dq_pkg::AMT_W-1:0]            removed;
	logic [dq_pkg::OCC_W-1:0]            occupancy;

	modport source (output valid, value_out, status, removed, occupancy, input ready);
	modport sink   (input valid, value_out, status, removed, occupancy, output ready);
endinterface

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words in a ring RAM.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the result queue has room; each
// operation makes at most one RAM access, at a slot derived from the front
// pointer and the element count, and the pointers update in the accept
// cycle. A result passes the registered RAM read, then the result queue.
// The four-entry result queue sets ready: with the output stalled, at most
// four results, the one in flight included, are held before requests stall.
// No clearing pass after reset; entries are only read once written.
module double_ended_queue #(
	parameter int unsigned DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	`include "double_ended_queue_defines.svh"

	localparam int unsigned AW = $clog2(DEPTH);

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic              space_ok;
	dq_pend_t          pend_s1;

	dq_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.space_ok (space_ok),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.pend_s1  (pend_s1)
	);

	dq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pend    (pend_s1),
		.rdata   (ram_rdata),
		.space_ok(space_ok),
		.rsp     (rsp)
	);

	`DQ_ASSERT_NOW(a_write_on_accept, clk, arst_n, ram_we, req.valid && req.ready)
	`DQ_ASSERT_NEXT(a_accept_reaches_back, clk, arst_n, req.valid && req.ready, pend_s1.valid)
	`DQ_ASSERT_NOW(a_full_no_value, clk, arst_n, rsp.valid && rsp.status == ST_FULL, rsp.value_out == 0 && rsp.removed == 0)
	`DQ_ASSERT_NOW(a_read_only_ok, clk, arst_n, pend_s1.valid && pend_s1.rd, pend_s1.rsp.status == ST_OK)

endmodule

[rtl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/dq_front.sv]
// ----------------------------------------------------------------------------
// dq_front
// Accepts requests, keeps the ring pointers, issues the RAM access and
// classifies the result.
// ----------------------------------------------------------------------------
module dq_front #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	dq_req_if.sink                   req,
	input  logic                     space_ok,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [dq_pkg::WORD_W-1:0] ram_wdata,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	output dq_pkg::dq_pend_t         pend_s1
);
	import dq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned MW = (CW > AMT_W) ? CW : AMT_W;

	logic [AW-1:0] front_q, front_d, prev_slot;
	logic [CW-1:0] held_q, held_d, read_off;
	logic [MW-1:0] held_ext, amt_ext, removed_c, pos_c;
	logic          accept, full, empty, amt_le_held, found, rd_c;
	logic [ST_W-1:0] status_c;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return AW'(sum);
	endfunction

	assign accept      = req.valid && space_ok;
	assign req.ready   = space_ok;
	assign full        = (held_q == CW'(DEPTH));
	assign empty       = (held_q == '0);
	assign prev_slot   = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign held_ext    = MW'(held_q);
	assign amt_ext     = MW'(req.amount);
	assign amt_le_held = (amt_ext <= held_ext);
	assign removed_c   = amt_le_held ? amt_ext : held_ext;
	assign pos_c       = (amt_ext <= MW'(1)) ? MW'(1) : amt_ext;
	assign found       = (pos_c <= held_ext);
	assign read_off    = CW'(pos_c - MW'(1));
	assign ram_wdata   = req.value_in;

	always_comb begin
		front_d   = front_q;
		held_d    = held_q;
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_raddr = front_q;
		rd_c      = 1'b0;
		status_c  = ST_OK;
		case (req.operation)
			OP_PUSH_REAR: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = slot_of(front_q, held_q);
					held_d    = held_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = prev_slot;
					front_d   = prev_slot;
					held_d    = held_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_c = ST_EMPTY;
				end else begin
					rd_c      = 1'b1;
					ram_raddr = front_q;
					front_d   = slot_of(front_q, CW'(1));
					held_d    = held_q - CW'(1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					status_c = ST_EMPTY;
				end else begin
					rd_c      = 1'b1;
					ram_raddr = slot_of(front_q, held_q - CW'(1));
					held_d    = held_q - CW'(1);
				end
			end
			OP_READ_POS: begin
				if (empty) begin
					status_c = ST_EMPTY;
				end else if (!found) begin
					status_c = ST_NOT_FOUND;
				end else begin
					rd_c      = 1'b1;
					ram_raddr = slot_of(front_q, read_off);
				end
			end
			OP_REMOVE_K: begin
				if (!amt_le_held) begin
					status_c = ST_EMPTY;
				end
				front_d = slot_of(front_q, CW'(removed_c));
				held_d  = held_q - CW'(removed_c);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			held_q  <= '0;
			pend_s1 <= '0;
		end else begin
			pend_s1.valid <= accept;
			if (accept) begin
				front_q                   <= front_d;
				held_q                    <= held_d;
				pend_s1.rd                <= rd_c;
				pend_s1.rsp.value_out     <= '0;
				pend_s1.rsp.status        <= status_c;
				pend_s1.rsp.removed       <= (req.operation == OP_REMOVE_K) ?
					AMT_W'(removed_c) : '0;
				pend_s1.rsp.occupancy     <= OCC_W'(held_d);
			end
		end
	end

endmodule

[rtl/dq_back.sv]
// ----------------------------------------------------------------------------
// dq_back
// Merges RAM read data into the result and queues results for the output.
// ----------------------------------------------------------------------------
module dq_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dq_pkg::dq_pend_t          pend,
	input  logic [dq_pkg::WORD_W-1:0] rdata,
	output logic                      space_ok,
	dq_rsp_if.source                  rsp
);
	import dq_pkg::*;

	dq_rsp_t          queue_q [RQ_DEPTH];
	dq_rsp_t          entry;
	logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_CW-1:0] count_q;
	logic             push, pop;

	always_comb begin
		entry = pend.rsp;
		if (pend.rd) begin
			entry.value_out = rdata;
		end
	end

	assign push     = pend.valid;
	assign pop      = rsp.valid && rsp.ready;
	assign space_ok = (count_q + RQ_CW'(pend.valid)) < RQ_CW'(RQ_DEPTH);

	assign rsp.valid     = (count_q != '0);
	assign rsp.value_out = queue_q[rd_ptr_q].value_out;
	assign rsp.status    = queue_q[rd_ptr_q].status;
	assign rsp.removed   = queue_q[rd_ptr_q].removed;
	assign rsp.occupancy = queue_q[rd_ptr_q].occupancy;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			count_q <= count_q + RQ_CW'(push) - RQ_CW'(pop);
		end
	end

endmodule

[tb/double_ended_queue_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque.
// ----------------------------------------------------------------------------
// A mirror of the deque state predicts each reply as its request is
// accepted, and replies are matched in order, field by field. The directed
// opening covers empty pops, empty reads, edge words and edge positions.
// Random fill, drain, mixed and spare-opcode runs follow. Both channels
// idle at random, and the reply side holds off for long stretches to back
// up the request channel.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int unsigned SLOTS        = 64;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned HOLD_CYCLES  = 300;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef logic [$clog2(SLOTS)-1:0] ring_idx_t;
	typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE} segment_kind_t;

	class deque_mirror;
		logic signed [WORD_W-1:0] words [SLOTS];
		ring_idx_t   head = '0;
		int unsigned held;
		dq_rsp_t     replies_due [$];
		int unsigned mismatches;
		int unsigned replies_seen;
		int unsigned full_drops;
		int unsigned empty_hits;
		int unsigned misses;

		function ring_idx_t slot_at(int unsigned offset);
			return ring_idx_t'(head + offset);
		endfunction

		function void take_request(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word,
				logic [AMT_W-1:0] amt);
			dq_rsp_t     r;
			int unsigned pos;
			r = '0;
			case (op)
			OP_PUSH_REAR: begin
				if (held >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					words[slot_at(held)] = word;
					held++;
				end
			end
			OP_PUSH_FRONT: begin
				if (held >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					head = head - 1'b1;
					words[head] = word;
					held++;
				end
			end
			OP_POP_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value_out = words[head];
					head = head + 1'b1;
					held--;
				end
			end
			OP_POP_REAR: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value_out = words[slot_at(held - 1)];
					held--;
				end
			end
			OP_READ_POS: begin
				pos = (amt <= 1) ? 1 : amt;
				if (held == 0)
					r.status = ST_EMPTY;
				else if (pos > held)
					r.status = ST_NOT_FOUND;
				else
					r.value_out = words[slot_at(pos - 1)];
			end
			OP_REMOVE_K: begin
				r.removed = (amt <= held) ? amt : AMT_W'(held);
				if (r.removed < amt)
					r.status = ST_EMPTY;
				head = slot_at(r.removed);
				held -= r.removed;
			end
			default: ;
			endcase
			r.occupancy = OCC_W'(held);
			case (r.status)
			ST_FULL:      full_drops++;
			ST_EMPTY:     empty_hits++;
			ST_NOT_FOUND: misses++;
			default: ;
			endcase
			replies_due.push_back(r);
		endfunction

		function void compare_field(string field, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d got %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void match_reply(dq_rsp_t got);
			dq_rsp_t want;
			replies_seen++;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply, expected none got value %0d status %0d",
					$time, got.value_out, got.status);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			compare_field("value_out", want.value_out, got.value_out);
			compare_field("status", want.status, got.status);
			compare_field("removed", want.removed, got.removed);
			compare_field("occupancy", want.occupancy, got.occupancy);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue #(
		.DEPTH (SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_mirror mirror = new();
	bit          sender_lazy;
	int unsigned requests_done;
	int unsigned stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (req_ch.valid === 1'b1 && req_ch.ready !== 1'b1)
			stall_cycles++;
	end

	task automatic offer_request(input logic [OP_W-1:0] op,
			input logic signed [WORD_W-1:0] word, input logic [AMT_W-1:0] amt);
		int gap;
		gap = sender_lazy ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.value_in  <= word;
		req_ch.amount    <= amt;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		mirror.take_request(op, word, amt);
		if (op <= OP_REMOVE_K)
			requests_done++;
	endtask

	task automatic run_segment(input segment_kind_t kind, input int len);
		logic [OP_W-1:0]  op;
		logic [AMT_W-1:0] amt;
		int unsigned      roll;
		for (int n = 0; n < len; n++) begin
			roll = $urandom_range(0, 7);
			amt  = AMT_W'($urandom);
			case (kind)
			SEG_FILL: begin
				if (roll == 0) begin
					op  = OP_READ_POS;
					amt = AMT_W'($urandom_range(0, mirror.held + 1));
				end else begin
					op = roll[0] ? OP_PUSH_REAR : OP_PUSH_FRONT;
				end
			end
			SEG_DRAIN: begin
				if (roll <= 2)
					op = OP_POP_FRONT;
				else if (roll <= 4)
					op = OP_POP_REAR;
				else if (roll == 5)
					op = OP_READ_POS;
				else begin
					op  = OP_REMOVE_K;
					amt = AMT_W'($urandom_range(0, 4));
				end
			end
			SEG_MIXED: begin
				op = OP_W'($urandom_range(0, 5));
				if (roll[0])
					amt = AMT_W'($urandom_range(0, mirror.held + 2));
			end
			default: op = roll[0] ? OP_SPARE_6 : OP_SPARE_7;
			endcase
			offer_request(op, $urandom, amt);
		end
	endtask

	// reply side: random gaps, lazy/eager stretches, two long hold-offs
	initial begin
		int          gap;
		int unsigned taken;
		bit          lazy;
		taken = 0;
		lazy  = 1'b1;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 50 == 0)
				lazy = $urandom_range(0, 2) != 0;
			if (taken == 400 || taken == 1300) begin
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
			end
			gap = lazy ? $urandom_range(0, 18) : 0;
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			mirror.match_reply('{rsp_ch.value_out, rsp_ch.status, rsp_ch.removed,
				rsp_ch.occupancy});
			taken++;
		end
	end

	initial begin
		segment_kind_t kind;
		int            len;
		int unsigned   roll;
		int unsigned   start_count;
		bit            first;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_PUSH_REAR;
		req_ch.value_in  <= '0;
		req_ch.amount    <= '0;
		sender_lazy = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store corners
		offer_request(OP_POP_FRONT, 32'sd5, 8'd0);
		offer_request(OP_POP_REAR, 32'sd6, 8'd0);
		offer_request(OP_READ_POS, 32'sd0, 8'd1);
		offer_request(OP_REMOVE_K, 32'sd0, 8'd0);
		offer_request(OP_REMOVE_K, 32'sd0, 8'd3);
		offer_request(OP_SPARE_6, 32'sd1, 8'd2);
		offer_request(OP_SPARE_7, -32'sd1, 8'd255);
		// edge words from both ends, front slot wraps below zero
		offer_request(OP_PUSH_REAR, 32'sh8000_0000, 8'd0);
		offer_request(OP_PUSH_FRONT, 32'sh7fff_ffff, 8'd255);
		offer_request(OP_PUSH_REAR, -32'sd1, 8'd0);
		offer_request(OP_PUSH_FRONT, 32'sd0, 8'd0);
		// positions: zero, first, last, one past, far past
		offer_request(OP_READ_POS, 32'sd0, 8'd0);
		offer_request(OP_READ_POS, 32'sd0, 8'd1);
		offer_request(OP_READ_POS, 32'sd0, 8'd4);
		offer_request(OP_READ_POS, 32'sd0, 8'd5);
		offer_request(OP_READ_POS, 32'sd0, 8'd255);
		offer_request(OP_POP_REAR, 32'sd0, 8'd0);
		offer_request(OP_POP_FRONT, 32'sd0, 8'd0);
		offer_request(OP_REMOVE_K, 32'sd0, 8'd1);
		offer_request(OP_REMOVE_K, 32'sd0, 8'd255);
		offer_request(OP_PUSH_FRONT, 32'sd77, 8'd0);
		offer_request(OP_POP_REAR, 32'sd0, 8'd0);

		start_count = requests_done;
		first = 1'b1;
		while (requests_done - start_count < RANDOM_ITEMS) begin
			sender_lazy = $urandom_range(0, 3) != 0;
			roll = $urandom_range(0, 9);
			if (first || roll <= 2) begin
				kind = SEG_FILL;
				len  = first ? 70 : $urandom_range(40, 75);
			end else if (roll <= 5) begin
				kind = SEG_DRAIN;
				len  = $urandom_range(20, 70);
			end else if (roll <= 8) begin
				kind = SEG_MIXED;
				len  = $urandom_range(20, 40);
			end else begin
				kind = SEG_NOISE;
				len  = $urandom_range(1, 3);
			end
			first = 1'b0;
			run_segment(kind, len);
		end
		req_ch.valid <= 1'b0;

		while (mirror.replies_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d replies: %0d full drops, %0d empty, %0d not found",
			requests_done, mirror.replies_seen, mirror.full_drops, mirror.empty_hits,
			mirror.misses);
		$display("%0d cycles with the request channel stalled", stall_cycles);
		if (mirror.mismatches == 0) begin
			$display("double_ended_queue test passed");
		end else begin
			$display("double_ended_queue test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d replies outstanding", $time, mirror.replies_due.size());
		$display("double_ended_queue test failed");
		$finish;
	end

endmodule
